@@ design/sfd_pkg.sv @@
// Shared types and constants for the SLIP frame decoder.
// No dependencies; imported by sfd_decode and slip_frame_decoder.
package sfd_pkg;

    localparam int MAX_PACKET = 256;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 9;
    localparam int IDX_W  = 3;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_START_CODE   = 3'd0;
    localparam logic [IDX_W-1:0] REG_END_CODE     = 3'd1;
    localparam logic [IDX_W-1:0] REG_ESCAPE_CODE  = 3'd2;
    localparam logic [IDX_W-1:0] REG_ESC_START    = 3'd3;
    localparam logic [IDX_W-1:0] REG_ESC_END      = 3'd4;
    localparam logic [IDX_W-1:0] REG_ESC_ESCAPE   = 3'd5;
    localparam logic [IDX_W-1:0] REG_MAX_LENGTH   = 3'd6;

    // Result kinds
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_DROP = 2'd2;

    // Drop causes
    localparam logic [1:0] CAUSE_NONE   = 2'd0;
    localparam logic [1:0] CAUSE_START  = 2'd1;
    localparam logic [1:0] CAUSE_ESCAPE = 2'd2;

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_FRAME = 2'd1,
        PH_ESC   = 2'd2
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] start_code;
        logic [BYTE_W-1:0] end_code;
        logic [BYTE_W-1:0] escape_code;
        logic [BYTE_W-1:0] escaped_start_code;
        logic [BYTE_W-1:0] escaped_end_code;
        logic [BYTE_W-1:0] escaped_escape_code;
        logic [LEN_W-1:0]  max_length;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [LEN_W-1:0]  position;
        logic              last;
        logic [1:0]        drop_cause;
    } result_t;

endpackage

@@ design/slip_frame_decoder.sv @@
// SLIP frame decoder top level: config registers, frame state, output buffer.
// Depends on sfd_pkg and sfd_decode.
//
// Takes one received byte per cycle while s_ready is high and gives at most one
// result per byte. The frame phase and byte count update on the clock edge that
// accepts the byte; its result is registered into the output buffer and shown on
// the m_ channel once any result ahead of it has gone. Results go through a
// two-entry output buffer, so s_ready depends only on buffer occupancy and input
// keeps flowing while one result waits on m_ready; s_ready falls only when both
// entries are full. Configuration writes are always ready and should be issued
// while no transactions are in flight.
module slip_frame_decoder (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [sfd_pkg::IDX_W-1:0]   cfg_index,
    input  logic [sfd_pkg::LEN_W-1:0]   cfg_data,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [sfd_pkg::BYTE_W-1:0]  s_rx_byte,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_kind,
    output logic [sfd_pkg::BYTE_W-1:0]  m_payload_byte,
    output logic [sfd_pkg::LEN_W-1:0]   m_position,
    output logic                        m_last,
    output logic [1:0]                  m_drop_cause
);
    import sfd_pkg::*;

    cfg_t             cfg_reg;
    phase_t           phase_reg;
    phase_t           phase_next;
    logic [LEN_W-1:0] byte_count_reg;
    logic [LEN_W-1:0] byte_count_next;
    logic             dec_emit;
    result_t          dec_res;

    result_t          out_reg;
    logic             out_valid_reg;
    result_t          skid_reg;
    logic             skid_valid_reg;

    logic             accept;
    logic             push;
    logic             pop;

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_valid_reg;
    assign accept    = s_valid && s_ready;
    assign push      = accept && dec_emit;
    assign pop       = out_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_code          <= 8'd193;
            cfg_reg.end_code            <= 8'd192;
            cfg_reg.escape_code         <= 8'd219;
            cfg_reg.escaped_start_code  <= 8'd222;
            cfg_reg.escaped_end_code    <= 8'd220;
            cfg_reg.escaped_escape_code <= 8'd221;
            cfg_reg.max_length          <= LEN_W'(MAX_PACKET);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_START_CODE:  cfg_reg.start_code          <= cfg_data[BYTE_W-1:0];
                REG_END_CODE:    cfg_reg.end_code            <= cfg_data[BYTE_W-1:0];
                REG_ESCAPE_CODE: cfg_reg.escape_code         <= cfg_data[BYTE_W-1:0];
                REG_ESC_START:   cfg_reg.escaped_start_code  <= cfg_data[BYTE_W-1:0];
                REG_ESC_END:     cfg_reg.escaped_end_code    <= cfg_data[BYTE_W-1:0];
                REG_ESC_ESCAPE:  cfg_reg.escaped_escape_code <= cfg_data[BYTE_W-1:0];
                REG_MAX_LENGTH:  cfg_reg.max_length          <= cfg_data;
                default: ;
            endcase
        end
    end

    sfd_decode u_decode (
        .rx_byte         (s_rx_byte),
        .phase           (phase_reg),
        .byte_count      (byte_count_reg),
        .cfg             (cfg_reg),
        .phase_next      (phase_next),
        .byte_count_next (byte_count_next),
        .emit            (dec_emit),
        .res             (dec_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HUNT;
            byte_count_reg <= '0;
        end else if (accept) begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
        end
    end

    // two-entry output buffer; skid only fills when the head is stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            priority if (skid_valid_reg) begin
                if (pop) begin
                    skid_valid_reg <= 1'b0;
                end
            end else if (push) begin
                if (out_valid_reg && !pop) begin
                    skid_valid_reg <= 1'b1;
                end else begin
                    out_valid_reg <= 1'b1;
                end
            end else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        priority if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (push) begin
            if (out_valid_reg && !pop) begin
                skid_reg <= dec_res;
            end else begin
                out_reg <= dec_res;
            end
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_kind         = out_reg.kind;
    assign m_payload_byte = out_reg.payload_byte;
    assign m_position     = out_reg.position;
    assign m_last         = out_reg.last;
    assign m_drop_cause   = out_reg.drop_cause;

    a_skid_behind_head: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty head");

    a_last_closes_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        push && dec_res.last |=> phase_reg == PH_HUNT && byte_count_reg == '0)
        else $error("frame not closed after last byte");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, byte_count_reg} < (LEN_W+1)'(MAX_PACKET))
        else $error("byte count reached packet limit");

    a_end_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_END |-> m_position != '0)
        else $error("end of packet reported with zero length");

endmodule

@@ design/sfd_decode.sv @@
// Per-byte decode: next phase, next byte count and the result of one byte.
// Purely combinational; depends on sfd_pkg.
module sfd_decode (
    input  logic [sfd_pkg::BYTE_W-1:0] rx_byte,
    input  sfd_pkg::phase_t            phase,
    input  logic [sfd_pkg::LEN_W-1:0]  byte_count,
    input  sfd_pkg::cfg_t              cfg,
    output sfd_pkg::phase_t            phase_next,
    output logic [sfd_pkg::LEN_W-1:0]  byte_count_next,
    output logic                       emit,
    output sfd_pkg::result_t           res
);
    import sfd_pkg::*;

    localparam logic [LEN_W:0] MAX_LIMIT = (LEN_W+1)'(MAX_PACKET);

    logic [LEN_W:0]    limit;
    logic [LEN_W:0]    count_inc;
    logic              reach;
    logic              escaped_hit;
    logic [BYTE_W-1:0] escaped_val;
    logic              plain_byte;

    // zero acts as one, anything above the packet buffer size is clamped
    always_comb begin
        priority if (cfg.max_length == '0) begin
            limit = (LEN_W+1)'(1);
        end else if ({1'b0, cfg.max_length} > MAX_LIMIT) begin
            limit = MAX_LIMIT;
        end else begin
            limit = {1'b0, cfg.max_length};
        end
    end

    assign count_inc = {1'b0, byte_count} + (LEN_W+1)'(1);
    assign reach     = (count_inc >= limit);

    always_comb begin
        escaped_hit = 1'b1;
        priority if (rx_byte == cfg.escaped_start_code) begin
            escaped_val = cfg.start_code;
        end else if (rx_byte == cfg.escaped_end_code) begin
            escaped_val = cfg.end_code;
        end else if (rx_byte == cfg.escaped_escape_code) begin
            escaped_val = cfg.escape_code;
        end else begin
            escaped_val = '0;
            escaped_hit = 1'b0;
        end
    end

    always_comb begin
        phase_next      = phase;
        byte_count_next = byte_count;
        emit            = 1'b0;
        plain_byte      = 1'b0;
        res             = '0;

        unique case (phase)
            PH_FRAME: begin
                priority if (rx_byte == cfg.start_code) begin
                    byte_count_next = '0;
                    emit            = 1'b1;
                    res.kind        = KIND_DROP;
                    res.drop_cause  = CAUSE_START;
                end else if (rx_byte == cfg.end_code) begin
                    // empty frame: end code ignored
                    if (byte_count != '0) begin
                        byte_count_next = '0;
                        phase_next      = PH_HUNT;
                        emit            = 1'b1;
                        res.kind        = KIND_END;
                        res.position    = byte_count;
                    end
                end else if (rx_byte == cfg.escape_code) begin
                    phase_next = PH_ESC;
                end else begin
                    plain_byte = 1'b1;
                end
            end
            PH_ESC: begin
                if (escaped_hit) begin
                    plain_byte = 1'b1;
                end else begin
                    byte_count_next = '0;
                    phase_next      = PH_FRAME;
                    emit            = 1'b1;
                    res.kind        = KIND_DROP;
                    res.drop_cause  = CAUSE_ESCAPE;
                end
            end
            default: begin
                phase_next = PH_HUNT;
                if (rx_byte == cfg.start_code) begin
                    phase_next      = PH_FRAME;
                    byte_count_next = '0;
                end
            end
        endcase

        if (plain_byte) begin
            emit             = 1'b1;
            res.kind         = KIND_BYTE;
            res.payload_byte = (phase == PH_ESC) ? escaped_val : rx_byte;
            res.position     = byte_count;
            if (reach) begin
                res.last        = 1'b1;
                byte_count_next = '0;
                phase_next      = PH_HUNT;
            end else begin
                byte_count_next = count_inc[LEN_W-1:0];
                phase_next      = PH_FRAME;
            end
        end
    end

endmodule
